// ===== design/min_tracking_stack_assert.svh =====
// Assertion macros for the min tracking stack.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define MTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define MTS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== design/mts_pkg.sv =====
// Shared types and codes for the min tracking stack.
// No dependencies.
package mts_pkg;

  typedef logic signed [31:0] word_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_POP_EMPTY = 2'd1,
    ERR_PUSH_FULL = 2'd2
  } err_e;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Shift command broadcast to every cell of a chain.
  typedef struct packed {
    logic push;
    logic pop;
  } mts_shift_t;

endpackage

// ===== design/mts_cell.sv =====
// One stack entry: takes its upper neighbor on push, its lower one on pop.
// Depends on mts_pkg.
module mts_cell (
  input  logic               clk_i,
  input  mts_pkg::mts_shift_t shift_i,
  input  mts_pkg::word_t     above_i,
  input  mts_pkg::word_t     below_i,
  output mts_pkg::word_t     q_o
);
  import mts_pkg::*;

  word_t entry_q;

  // Payload only: contents are meaningless until pushed.
  always_ff @(posedge clk_i) begin
    if (shift_i.push) begin
      entry_q <= above_i;
    end else if (shift_i.pop) begin
      entry_q <= below_i;
    end
  end

  assign q_o = entry_q;
endmodule

// ===== design/mts_chain.sv =====
// A row of mts_cell entries forming a shift stack, top at cell 0.
// Depends on mts_pkg and mts_cell.
module mts_chain #(
  parameter int DEPTH = 64
) (
  input  logic               clk_i,
  input  mts_pkg::mts_shift_t shift_i,
  input  mts_pkg::word_t     push_data_i,
  output mts_pkg::word_t     top_o,
  output mts_pkg::word_t     next_o
);
  import mts_pkg::*;

  word_t cell_q [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    word_t above, below;
    if (k == 0) begin : g_first
      assign above = push_data_i;
    end else begin : g_mid
      assign above = cell_q[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cell_q[k+1];
    end
    mts_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_i),
      .above_i (above),
      .below_i (below),
      .q_o     (cell_q[k])
    );
  end

  assign top_o  = cell_q[0];
  assign next_o = cell_q[1];
endmodule

// ===== design/min_tracking_stack.sv =====
// Min tracking stack: a signed 32-bit stack that also reports its minimum.
// Depends on mts_pkg, mts_chain, mts_cell and min_tracking_stack_assert.svh.
//
// Input channel (in_valid_i / in_ready_o): one request per handshake, either
// a push of push_value_i (opcode OP_PUSH) or a pop (opcode OP_POP).
// Output channel (out_valid_o / out_ready_i): exactly one result per request,
// carrying the new top, the current minimum, an empty flag and an error code.
// Top and minimum read as zero when the stack is empty. Popping an empty
// stack or pushing a full one leaves the stack unchanged and sets error_code.
//
// Storage is two shift chains of STACK_DEPTH cells, top at cell 0: the value
// chain and a minimum chain holding every push that was at or below the
// running minimum. A request shifts the value chain and, where needed, the
// minimum chain in the same cycle, so the top entries stay at fixed cells.
// The registered result appears in the cycle after the request is taken.
// Throughput: one request per cycle, set by the single output register;
// a new request is taken whenever that register is empty or being drained.
// If the receiver stalls, the result is held and no request is taken.
// Reset clears both counts and the output valid; cell contents stay unknown
// and are never shown, as the counts gate every read.
module min_tracking_stack #(
  parameter int STACK_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           opcode_i,
  input  mts_pkg::word_t push_value_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mts_pkg::word_t top_value_o,
  output mts_pkg::word_t min_value_o,
  output logic           is_empty_o,
  output logic [1:0]     error_code_o
);
  import mts_pkg::*;

  `include "min_tracking_stack_assert.svh"

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  logic [CW-1:0] val_cnt_q, val_cnt_d;
  logic [CW-1:0] min_cnt_q, min_cnt_d;

  logic  out_valid_q;
  word_t top_q, top_d;
  word_t min_q, min_d;
  logic  empty_q, empty_d;
  err_e  err_q, err_d;

  word_t val_top, val_next, min_top, min_next;
  mts_shift_t val_shift, min_shift;

  logic take, is_push, do_push, do_pop, min_push, min_pop;

  // Take a request whenever the result register is free or draining.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign is_push    = (opcode_i == OP_PUSH);

  assign do_push  = take && is_push && (val_cnt_q != FULL_CNT);
  assign do_pop   = take && !is_push && (val_cnt_q != '0);
  // Record a new minimum when it is at or below the current one, or none is held.
  assign min_push = do_push && ((min_cnt_q == '0) || (push_value_i <= min_top));
  // Drop the minimum when the popped value is that minimum.
  assign min_pop  = do_pop && (min_cnt_q != '0) && (val_top == min_top);

  assign val_shift = '{push: do_push,  pop: do_pop};
  assign min_shift = '{push: min_push, pop: min_pop};

  mts_chain #(.DEPTH(STACK_DEPTH)) u_val_chain (
    .clk_i       (clk_i),
    .shift_i     (val_shift),
    .push_data_i (push_value_i),
    .top_o       (val_top),
    .next_o      (val_next)
  );

  mts_chain #(.DEPTH(STACK_DEPTH)) u_min_chain (
    .clk_i       (clk_i),
    .shift_i     (min_shift),
    .push_data_i (push_value_i),
    .top_o       (min_top),
    .next_o      (min_next)
  );

  always_comb begin
    val_cnt_d = val_cnt_q;
    min_cnt_d = min_cnt_q;
    if (do_push) val_cnt_d = val_cnt_q + ONE_CNT;
    if (do_pop)  val_cnt_d = val_cnt_q - ONE_CNT;
    if (min_push) min_cnt_d = min_cnt_q + ONE_CNT;
    if (min_pop)  min_cnt_d = min_cnt_q - ONE_CNT;

    // Result as seen after the shift.
    if (do_push) begin
      top_d = push_value_i;
    end else if (do_pop) begin
      top_d = val_next;
    end else begin
      top_d = val_top;
    end
    if (min_push) begin
      min_d = push_value_i;
    end else if (min_pop) begin
      min_d = min_next;
    end else begin
      min_d = min_top;
    end
    empty_d = (val_cnt_d == '0);
    if (empty_d) begin
      top_d = '0;
      min_d = '0;
    end

    if (is_push && !do_push) begin
      err_d = ERR_PUSH_FULL;
    end else if (!is_push && !do_pop) begin
      err_d = ERR_POP_EMPTY;
    end else begin
      err_d = ERR_OK;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_cnt_q   <= '0;
      min_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      val_cnt_q <= val_cnt_d;
      min_cnt_q <= min_cnt_d;
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on every taken request, hold while stalled.
  always_ff @(posedge clk_i) begin
    if (take) begin
      top_q   <= top_d;
      min_q   <= min_d;
      empty_q <= empty_d;
      err_q   <= err_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign top_value_o  = top_q;
  assign min_value_o  = min_q;
  assign is_empty_o   = empty_q;
  assign error_code_o = err_q;

  // The minimum chain never outgrows the value chain.
  `MTS_ASSERT_NEVER(a_min_bounded, min_cnt_q > val_cnt_q, "minimum count exceeds value count")
  // A non-empty stack always has a minimum entry.
  `MTS_ASSERT_NEVER(a_min_present, (val_cnt_q != '0) && (min_cnt_q == '0), "minimum chain empty")
  // Every taken request yields a result in the next cycle.
  `MTS_ASSERT(a_result_follows, take |=> out_valid_o, "taken request produced no result")
  // Empty results read as zero.
  `MTS_ASSERT(a_empty_zero, out_valid_o && is_empty_o |-> top_value_o == '0 && min_value_o == '0, "empty result not zero")
endmodule
